FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL. Each check is sampled on the rising
// edge of clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(name, expr, msg)
`define ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

FILE: rtl/core/gnsl_pkg.sv
// ----------------------------------------------------------------------------
// gnsl_pkg
// Shared widths, register indexes, reset values and controller/datapath
// interface types for the sum-of-uniforms Gaussian noise generator.
// ----------------------------------------------------------------------------
package gnsl_pkg;

    localparam int LCG_W      = 20;
    localparam int MEAN_W     = 20;
    localparam int SIGMA_W    = 16;
    localparam int OUT_W      = 21;
    localparam int FRAC_SHIFT = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int NUM_UNIFORMS_DEF = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_Q12     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_Q12    = 2'd2;

    localparam logic [LCG_W-1:0]   SEED_RESET  = 20'd1;
    localparam logic [MEAN_W-1:0]  MEAN_RESET  = 20'd0;
    localparam logic [SIGMA_W-1:0] SIGMA_RESET = 16'd4096;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;  // reload the seed if restart is high, clear the sum and the step counter
        logic step;   // one generator update, accumulate the new state
        logic mult;   // register the centered sum times sigma
        logic emit;   // load the output register
    } gnsl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_step;
    } gnsl_status_t;

endpackage

FILE: rtl/core/gnsl_ctrl.sv
// ----------------------------------------------------------------------------
// gnsl_ctrl
// Sequencer for one sample: accept, step the generator, scale, then hand
// the result to the output register once it is free.
// ----------------------------------------------------------------------------
module gnsl_ctrl
    import gnsl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  gnsl_status_t status,
    output gnsl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_MUL,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd.start = (state_reg == ST_IDLE) && in_valid;
        cmd.step  = (state_reg == ST_RUN);
        cmd.mult  = (state_reg == ST_MUL);
        cmd.emit  = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (status.last_step)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (cmd.emit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/gnsl_dp.sv
// ----------------------------------------------------------------------------
// gnsl_dp
// Datapath: configuration registers, generator state, running sum, step
// counter, scaling multiplier and output register.
// ----------------------------------------------------------------------------
module gnsl_dp
    import gnsl_pkg::*;
#(
    parameter int NUM_UNIFORMS = NUM_UNIFORMS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        restart,
    input  gnsl_cmd_t                   cmd,
    output gnsl_status_t                status,
    output logic signed [OUT_W-1:0]     sample_q12
);

    localparam int SUM_W  = LCG_W + $clog2(NUM_UNIFORMS);
    localparam int PROD_W = SUM_W + 1 + SIGMA_W + 1;
    localparam int CNT_W  = (NUM_UNIFORMS > 1) ? $clog2(NUM_UNIFORMS) : 1;
    // Half of full scale per uniform centers the sum around zero.
    localparam logic [SUM_W:0] OFFSET = (SUM_W + 1)'(NUM_UNIFORMS * (2 ** (LCG_W - 1)));
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_UNIFORMS - 1);

    logic [LCG_W-1:0]          seed_reg;
    logic signed [MEAN_W-1:0]  mean_reg;
    logic [SIGMA_W-1:0]        sigma_reg;

    logic [LCG_W-1:0]          lcg_reg;
    logic [LCG_W-1:0]          lcg_next;
    logic [SUM_W-1:0]          sum_reg;
    logic [SUM_W-1:0]          sum_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [SUM_W:0]     centered;
    logic signed [SIGMA_W:0]   sigma_s;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_shifted;
    logic signed [OUT_W-1:0]   sample_reg;
    logic signed [OUT_W-1:0]   sample_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= SEED_RESET;
            mean_reg  <= MEAN_RESET;
            sigma_reg <= SIGMA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INITIAL_SEED: seed_reg  <= cfg_data[LCG_W-1:0];
                CFG_MEAN_Q12:     mean_reg  <= cfg_data[MEAN_W-1:0];
                CFG_SIGMA_Q12:    sigma_reg <= cfg_data[SIGMA_W-1:0];
                default:          ;
            endcase
        end
    end

    // Next state 2045 * s + 1, with 2045 * s = 2048 * s - 2 * s - s, taken modulo 2^20.
    always_comb
    begin
        lcg_next = {lcg_reg[LCG_W-12:0], 11'b0} - {lcg_reg[LCG_W-2:0], 1'b0}
                 - lcg_reg + LCG_W'(1);
        sum_next = sum_reg + SUM_W'(lcg_next);
    end

    always_comb
    begin
        centered     = $signed({1'b0, sum_reg}) - $signed(OFFSET);
        sigma_s      = $signed({1'b0, sigma_reg});
        prod_next    = PROD_W'(centered) * PROD_W'(sigma_s);
        prod_shifted = prod_reg >>> FRAC_SHIFT;
        sample_next  = prod_shifted[OUT_W-1:0] + OUT_W'(mean_reg);
    end

    // The generator state is control-visible, so it resets to the seed reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lcg_reg <= SEED_RESET;
        else if (cmd.start && restart)
            lcg_reg <= seed_reg;
        else if (cmd.step)
            lcg_reg <= lcg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.start)
            cnt_reg <= '0;
        else if (cmd.step)
            cnt_reg <= cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            sum_reg <= '0;
        else if (cmd.step)
            sum_reg <= sum_next;
        if (cmd.mult)
            prod_reg <= prod_next;
        if (cmd.emit)
            sample_reg <= sample_next;
    end

    assign status.last_step = (cnt_reg == LAST_CNT);
    assign sample_q12       = sample_reg;

endmodule

FILE: rtl/core/gaussian_noise_sum_of_twelve_lcg_core.sv
// ----------------------------------------------------------------------------
// gaussian_noise_sum_of_twelve_lcg_core
// Approximate Gaussian noise from the sum of NUM_UNIFORMS LCG uniforms,
// scaled by sigma and offset by the mean, signed Q.12.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the input channel (in_valid, in_stall, restart) requests
// one sample; with restart high the generator reloads initial_seed first.
// The sample leaves on the output channel (out_valid, out_stall, sample_q12).
// A request is taken at the edge where in_valid is high and in_stall low.
// The generator state is advanced once per cycle by a shift-add update; a
// sample is accepted, takes NUM_UNIFORMS generator steps, is multiplied and
// is then loaded into the output register, which raises out_valid. A new
// request is taken in the cycle after that load.
// The output register holds the sample while out_stall is high; the next
// request is still taken and computed, then waits until the register frees.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// ready and are meant to happen only while the block is idle.
// Reset sets initial_seed to 1, mean to 0, sigma to 1.0 and the generator
// state to 1, and leaves both channels empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gaussian_noise_sum_of_twelve_lcg_core
    import gnsl_pkg::*;
#(
    parameter int NUM_UNIFORMS = NUM_UNIFORMS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      restart,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [OUT_W-1:0]   sample_q12
);

    gnsl_cmd_t    cmd;
    gnsl_status_t status;
    logic         cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    gnsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gnsl_dp #(
        .NUM_UNIFORMS (NUM_UNIFORMS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .restart    (restart),
        .cmd        (cmd),
        .status     (status),
        .sample_q12 (sample_q12)
    );

    `ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "controller issued two commands at once")
    `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "in_stall low after accept")
    `ASSERT_NEXT(a_emit_sets_valid, cmd.emit, out_valid, "output register loaded without valid")

endmodule
